FILE: design/i2crs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crs_pkg
// Shared types and codes for the I2C register read sequencer.
// ----------------------------------------------------------------------------
package i2crs_pkg;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;

    localparam int unsigned ADDR_W = 7;
    localparam int unsigned BYTE_W = 8;

    // transmit phase, one-hot
    typedef enum logic [3:0] {
        PH_SLAVE_WR = 4'b0001,
        PH_REG_ADDR = 4'b0010,
        PH_RESTART  = 4'b0100,
        PH_RECEIVE  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] register_address;
        logic [BYTE_W-1:0] byte_count;
        logic              bus_busy;
        logic              ack_received;
        logic [BYTE_W-1:0] rx_data;
    } req_item_t;

    typedef struct packed {
        logic              tx_write;
        logic [BYTE_W-1:0] tx_byte;
        logic              master_start;
        logic              repeated_start;
        logic              enter_receive;
        logic              dummy_read;
        logic              send_nack;
        logic              stop_bus;
        logic              store_valid;
        logic [BYTE_W-1:0] store_index;
        logic [BYTE_W-1:0] store_byte;
        logic              done_res;
    } res_item_t;

endpackage

FILE: design/i2crs_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crs channels
// Valid/ready channel interfaces for requests, results and configuration.
// ----------------------------------------------------------------------------
interface i2crs_req_if;
    import i2crs_pkg::*;
    logic      valid;
    logic      ready;
    req_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2crs_res_if;
    import i2crs_pkg::*;
    logic      valid;
    logic      ready;
    res_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2crs_cfg_if;
    import i2crs_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/i2crs_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crs_sequencer
// Sequencer state and the single-pass result logic for one transaction.
// ----------------------------------------------------------------------------
module i2crs_sequencer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fire,
    input  i2crs_pkg::req_item_t             item,
    input  logic [i2crs_pkg::ADDR_W-1:0]     slave_address,
    output i2crs_pkg::res_item_t             result
);
    import i2crs_pkg::*;

    logic              active_reg,   active_next;
    logic              transmit_reg, transmit_next;
    phase_t            phase_reg,    phase_next;
    logic [BYTE_W-1:0] count_reg,    count_next;
    logic [BYTE_W-1:0] wanted_reg,   wanted_next;
    logic [BYTE_W-1:0] held_reg,     held_next;

    logic [BYTE_W:0]   count_p1;
    logic [BYTE_W:0]   count_p2;

    assign count_p1 = {1'b0, count_reg} + (BYTE_W+1)'(1);
    assign count_p2 = {1'b0, count_reg} + (BYTE_W+1)'(2);

    always_comb
    begin
        active_next   = active_reg;
        transmit_next = transmit_reg;
        phase_next    = phase_reg;
        count_next    = count_reg;
        wanted_next   = wanted_reg;
        held_next     = held_reg;
        result        = '0;

        if (item.kind == KIND_START)
        begin
            if (item.byte_count != '0)
            begin
                active_next         = 1'b1;
                transmit_next       = 1'b1;
                phase_next          = PH_SLAVE_WR;
                count_next          = '0;
                wanted_next         = item.byte_count;
                held_next           = item.register_address;
                result.master_start = 1'b1;
                result.tx_write     = 1'b1;
                result.tx_byte      = {slave_address, RW_WRITE};
            end
        end
        else if (active_reg && item.bus_busy)
        begin
            if (transmit_reg)
            begin
                if (!item.ack_received)
                begin
                    result.stop_bus = 1'b1;
                    active_next     = 1'b0;
                    transmit_next   = 1'b0;
                    phase_next      = PH_SLAVE_WR;
                    count_next      = '0;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_SLAVE_WR:
                        begin
                            phase_next      = PH_REG_ADDR;
                            result.tx_write = 1'b1;
                            result.tx_byte  = held_reg;
                        end
                        PH_REG_ADDR:
                        begin
                            phase_next            = PH_RESTART;
                            result.repeated_start = 1'b1;
                            result.tx_write       = 1'b1;
                            result.tx_byte        = {slave_address, RW_READ};
                        end
                        PH_RESTART:
                        begin
                            phase_next           = PH_RECEIVE;
                            transmit_next        = 1'b0;
                            result.enter_receive = 1'b1;
                            result.dummy_read    = 1'b1;
                        end
                        PH_RECEIVE: ;   // unreachable while transmitting
                        default: ;
                    endcase
                end
            end
            else if (count_reg < wanted_reg)
            begin
                result.store_valid = 1'b1;
                result.store_index = count_reg;
                result.store_byte  = item.rx_data;
                if (count_p1 == {1'b0, wanted_reg})
                begin
                    // last byte
                    result.stop_bus = 1'b1;
                    result.done_res = 1'b1;
                    active_next     = 1'b0;
                    transmit_next   = 1'b0;
                    phase_next      = PH_SLAVE_WR;
                    count_next      = '0;
                end
                else
                begin
                    result.send_nack = (count_p2 == {1'b0, wanted_reg});
                    count_next       = count_p1[BYTE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            transmit_reg <= 1'b0;
            phase_reg    <= PH_SLAVE_WR;
            count_reg    <= '0;
            wanted_reg   <= '0;
            held_reg     <= '0;
        end
        else if (fire)
        begin
            active_reg   <= active_next;
            transmit_reg <= transmit_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            wanted_reg   <= wanted_next;
            held_reg     <= held_next;
        end
    end

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (count_reg == '0 && phase_reg == PH_SLAVE_WR))
        else $error("idle sequencer holds stale counter or phase");

    a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.done_res) |=> !active_reg)
        else $error("sequencer still active after done");

    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.kind == KIND_START && item.byte_count != '0)
        |=> (active_reg && transmit_reg && count_reg == '0))
        else $error("start request did not arm the sequencer");

    a_rx_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && !transmit_reg) |-> phase_reg == PH_RECEIVE)
        else $error("receive mode outside the receive phase");

endmodule

FILE: design/i2crs_result_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crs_result_buffer
// Result register with one skid entry toward the result channel.
// ----------------------------------------------------------------------------
module i2crs_result_buffer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  i2crs_pkg::res_item_t  push_data,
    output logic                  room,
    i2crs_res_if.source           res
);
    import i2crs_pkg::*;

    logic      out_valid_reg,  out_valid_next;
    res_item_t out_reg,        out_next;
    logic      skid_valid_reg, skid_valid_next;
    res_item_t skid_reg,       skid_next;
    logic      pop;

    assign pop       = out_valid_reg && res.ready;
    assign room      = !skid_valid_reg;
    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (pop && skid_valid_reg)
        begin
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
        else if (pop || !out_valid_reg)
        begin
            out_valid_next = push;
            out_next       = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a head entry");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed into a full buffer");

    a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && skid_valid_reg) |=> (out_valid_reg && out_reg == $past(skid_reg)))
        else $error("skid entry lost on pop");

endmodule

FILE: design/i2crs_input_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crs_input_stage
// Request input register; hands one transaction per cycle to the sequencer while the result buffer has room.
// ----------------------------------------------------------------------------
module i2crs_input_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    i2crs_req_if.sink             req,
    input  logic                  room,
    output logic                  fire,
    output i2crs_pkg::req_item_t  item
);
    import i2crs_pkg::*;

    logic      valid_reg;
    req_item_t item_reg;

    assign fire      = valid_reg && room;
    assign req.ready = !valid_reg || room;
    assign item      = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (req.ready)
            valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
            item_reg <= req.data;
    end

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !room) |=> (valid_reg && $stable(item_reg)))
        else $error("stalled request dropped or changed");

endmodule

FILE: design/i2crs_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_read_sequencer_core
// Event-driven I2C master register read with repeated start.
//
//   channel | dir | payload              | handshake
//   --------+-----+----------------------+---------------------------
//   req     | in  | req_item_t (6 flds)  | valid & ready
//   res     | out | res_item_t (12 flds) | valid & ready
//   cfg     | in  | slave_address[6:0]   | valid & ready, always ready
//
// One transaction per cycle sustained while the result channel keeps up; each
// request gives exactly one result (input register, then result register).
// The sequencer state updates as the request leaves the input register.
// Reset (rst_n low, async) returns to idle with slave_address 0.
// A stalled result channel fills the one-entry skid; req.ready drops only
// once the skid is occupied and the input register holds a request.
// ----------------------------------------------------------------------------
module i2c_register_read_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    i2crs_req_if.sink   req,
    i2crs_res_if.source res,
    i2crs_cfg_if.sink   cfg
);
    import i2crs_pkg::*;

    logic [ADDR_W-1:0] slave_address_reg;
    logic              room;
    logic              fire;
    req_item_t         item;
    res_item_t         result;

    // Config writes must arrive only while idle; the user is bound, the block does not enforce it (no interlock here).
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slave_address_reg <= '0;
        else if (cfg.valid)
            slave_address_reg <= cfg.data;
    end

    i2crs_input_stage u_input (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .room  (room),
        .fire  (fire),
        .item  (item)
    );

    // decode of the held request against the sequencer state
    i2crs_sequencer u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .item          (item),
        .slave_address (slave_address_reg),
        .result        (result)
    );

    // result register plus skid toward the consumer
    i2crs_result_buffer u_res (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (result),
        .room      (room),
        .res       (res)
    );

endmodule

FILE: dv/tb_i2c_register_read_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_register_read_sequencer_core
// Self-checking bench for the I2C register read sequencer. A directed table
// walks reset values, field extremes and the corner cases (ignored start,
// idle/not-busy events, NACK abort, restart while active, one-byte and
// two-byte reads). Randomized register reads with stray events, NACK aborts
// and abandoned transactions follow, under three idle/stall mixes and
// several slave addresses. Every result is compared field by field against
// a typed expectation or an in-bench model of the sequencer.
// ----------------------------------------------------------------------------
module tb_i2c_register_read_sequencer_core;
    import i2crs_pkg::*;

    // Cycles with no transaction on any channel before the run is declared hung
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        bit                set_addr;   // write slave_address before this row
        logic [ADDR_W-1:0] addr_val;
        req_item_t         item;
        bit                typed;      // use want instead of the model
        res_item_t         want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    i2crs_req_if req_ch ();
    i2crs_res_if res_ch ();
    i2crs_cfg_if cfg_ch ();

    i2c_register_read_sequencer_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Sequencer model state (mirrors the block's architectural state)
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] slave_addr_q;
    logic              seq_active;
    phase_t            seq_phase;      // PH_RECEIVE means receive mode
    logic [BYTE_W-1:0] rx_count;
    logic [BYTE_W-1:0] rx_wanted;
    logic [BYTE_W-1:0] held_reg;

    res_item_t pending_results[$];     // predicted results, oldest first
    dir_row_t  dir_rows[$];

    int src_idle_pct;
    int snk_idle_pct;
    int fail_count;
    int stall_cycles;

    // run statistics
    int req_total;
    int start_total;
    int event_total;
    int live_items;                    // requests other than not-busy events and zero-count starts
    int cfg_writes;
    int reads_done;
    int nack_stops;
    int bytes_stored;

    // ------------------------------------------------------------------
    // Clock: 10 ns period
    // ------------------------------------------------------------------
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Result builders, shared by the directed table and the model
    // ------------------------------------------------------------------
    function automatic res_item_t r_tx(input logic start, input logic rep,
                                       input logic [BYTE_W-1:0] b);
        res_item_t r;
        r                = '0;
        r.tx_write       = 1'b1;
        r.tx_byte        = b;
        r.master_start   = start;
        r.repeated_start = rep;
        return r;
    endfunction

    function automatic res_item_t r_store(input logic [BYTE_W-1:0] idx,
                                          input logic [BYTE_W-1:0] b,
                                          input logic nack, input logic last);
        res_item_t r;
        r             = '0;
        r.store_valid = 1'b1;
        r.store_index = idx;
        r.store_byte  = b;
        r.send_nack   = nack;
        r.stop_bus    = last;
        r.done_res    = last;
        return r;
    endfunction

    function automatic req_item_t start_req(input logic [BYTE_W-1:0] reg_addr,
                                            input logic [BYTE_W-1:0] count);
        req_item_t it;
        it                  = '0;
        it.kind             = KIND_START;
        it.register_address = reg_addr;
        it.byte_count       = count;
        return it;
    endfunction

    function automatic req_item_t bus_event(input logic busy, input logic ack,
                                            input logic [BYTE_W-1:0] rx);
        req_item_t it;
        it              = '0;
        it.kind         = KIND_EVENT;
        it.bus_busy     = busy;
        it.ack_received = ack;
        it.rx_data      = rx;
        return it;
    endfunction

    function automatic req_item_t random_req();
        req_item_t it;
        it.kind             = 1'($urandom_range(1));
        it.register_address = 8'($urandom_range(255));
        it.byte_count       = 8'($urandom_range(255));
        it.bus_busy         = 1'($urandom_range(1));
        it.ack_received     = 1'($urandom_range(1));
        it.rx_data          = 8'($urandom_range(255));
        return it;
    endfunction

    // Mostly short reads; a few medium ones. The 255-byte read is forced once.
    function automatic logic [BYTE_W-1:0] pick_count();
        if ($urandom_range(99) < 88)
            return 8'($urandom_range(6, 1));
        return 8'($urandom_range(40, 7));
    endfunction

    // ------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------
    function automatic void drop_to_idle();
        seq_active = 1'b0;
        seq_phase  = PH_SLAVE_WR;
        rx_count   = '0;
    endfunction

    // Advances the model by one request and returns the bus action it causes
    function automatic res_item_t predict_bus_action(input req_item_t it);
        res_item_t r;
        r = '0;
        if (it.kind == KIND_START) begin
            // zero byte count: request dropped, state untouched
            if (it.byte_count != '0) begin
                // a start while active simply abandons the running read
                seq_active = 1'b1;
                seq_phase  = PH_SLAVE_WR;
                rx_count   = '0;
                rx_wanted  = it.byte_count;
                held_reg   = it.register_address;
                r = r_tx(1'b1, 1'b0, {slave_addr_q, RW_WRITE});
            end
        end
        else if (seq_active && it.bus_busy) begin
            if (seq_phase != PH_RECEIVE) begin
                if (!it.ack_received) begin
                    // slave refused the byte: stop and go idle
                    r.stop_bus = 1'b1;
                    drop_to_idle();
                end
                else begin
                    case (seq_phase)
                        PH_SLAVE_WR:
                        begin
                            seq_phase = PH_REG_ADDR;
                            r = r_tx(1'b0, 1'b0, held_reg);
                        end
                        PH_REG_ADDR:
                        begin
                            seq_phase = PH_RESTART;
                            r = r_tx(1'b0, 1'b1, {slave_addr_q, RW_READ});
                        end
                        default:
                        begin
                            seq_phase       = PH_RECEIVE;
                            r.enter_receive = 1'b1;
                            r.dummy_read    = 1'b1;
                        end
                    endcase
                end
            end
            else if (rx_count < rx_wanted) begin
                // receive mode ignores the ACK bit; last byte stops and finishes
                if (int'(rx_count) + 1 == int'(rx_wanted)) begin
                    r = r_store(rx_count, it.rx_data, 1'b0, 1'b1);
                    drop_to_idle();
                end
                else begin
                    r = r_store(rx_count, it.rx_data,
                                int'(rx_count) + 2 == int'(rx_wanted), 1'b0);
                    rx_count = rx_count + 8'd1;
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: random gap, then hold valid until accepted
    // ------------------------------------------------------------------
    task automatic send_req(input req_item_t it, input bit typed,
                            input res_item_t want);
        res_item_t predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // model steps at acceptance so it stays in order with the block
        predicted = predict_bus_action(it);
        pending_results.push_back(typed ? want : predicted);
        req_total++;
        if (it.kind == KIND_START)
            start_total++;
        else
            event_total++;
        if (!(it.kind == KIND_EVENT && !it.bus_busy) &&
            !(it.kind == KIND_START && it.byte_count == '0))
            live_items++;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Config writes only happen with no request in flight and every result drained
    task automatic write_slave_address(input logic [ADDR_W-1:0] v);
        hold_until_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        slave_addr_q = v;
        cfg_writes++;
    endtask

    // One read transaction: start, then steps well-formed events, then an
    // optional NACK. steps = count + 3 runs the read to completion.
    task automatic run_read(input logic [BYTE_W-1:0] count, input int steps,
                            input bit nack_end);
        req_item_t it;
        int        n;
        it            = random_req();
        it.kind       = KIND_START;
        it.byte_count = count;
        send_req(it, 1'b0, '0);
        for (n = 0; n < steps; n++) begin
            // occasional event with the bus not busy: must be ignored
            if ($urandom_range(99) < 4) begin
                it          = random_req();
                it.kind     = KIND_EVENT;
                it.bus_busy = 1'b0;
                send_req(it, 1'b0, '0);
            end
            it          = random_req();
            it.kind     = KIND_EVENT;
            it.bus_busy = 1'b1;
            if (n < 3)
                it.ack_received = 1'b1;   // transmit phases need the ACK
            send_req(it, 1'b0, '0);
        end
        if (nack_end) begin
            it              = random_req();
            it.kind         = KIND_EVENT;
            it.bus_busy     = 1'b1;
            it.ack_received = 1'b0;
            send_req(it, 1'b0, '0);
        end
    endtask

    task automatic random_phase(input int target);
        int               base;
        int               pick;
        logic [BYTE_W-1:0] count;
        base = live_items;
        while (live_items - base < target) begin
            pick  = $urandom_range(99);
            count = pick_count();
            if (pick < 78)
                run_read(count, int'(count) + 3, 1'b0);          // complete read
            else if (pick < 88)
                run_read(count, $urandom_range(2), 1'b1);        // NACK abort
            else if (pick < 94)
                run_read(count, $urandom_range(int'(count) + 2), 1'b0); // abandoned
            else
                send_req(random_req(), 1'b0, '0);                // raw noise
            if ($urandom_range(99) < 3)
                hold_until_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        res_item_t want;
        res_item_t got;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected");
                fail_count++;
            end
            else begin
                want = pending_results.pop_front();
                check_field("tx_write",       want.tx_write,       got.tx_write);
                check_field("tx_byte",        want.tx_byte,        got.tx_byte);
                check_field("master_start",   want.master_start,   got.master_start);
                check_field("repeated_start", want.repeated_start, got.repeated_start);
                check_field("enter_receive",  want.enter_receive,  got.enter_receive);
                check_field("dummy_read",     want.dummy_read,     got.dummy_read);
                check_field("send_nack",      want.send_nack,      got.send_nack);
                check_field("stop_bus",       want.stop_bus,       got.stop_bus);
                check_field("store_valid",    want.store_valid,    got.store_valid);
                check_field("store_index",    want.store_index,    got.store_index);
                check_field("store_byte",     want.store_byte,     got.store_byte);
                check_field("done_res",       want.done_res,       got.done_res);
            end
            if (got.done_res === 1'b1)
                reads_done++;
            if (got.stop_bus === 1'b1 && got.done_res !== 1'b1)
                nack_stops++;
            if (got.store_valid === 1'b1)
                bytes_stored++;
        end
    end

    // Result side back-pressure
    always @(posedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles with no transaction on any channel
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        res_item_t halt;
        res_item_t rx_enter;
        req_item_t ev;

        clk          = 1'b0;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        src_idle_pct = 32;
        snk_idle_pct = 64;
        fail_count   = 0;
        stall_cycles = 0;
        req_total    = 0;
        start_total  = 0;
        event_total  = 0;
        live_items   = 0;
        cfg_writes   = 0;
        reads_done   = 0;
        nack_stops   = 0;
        bytes_stored = 0;

        // model reset values
        slave_addr_q = '0;
        rx_wanted    = '0;
        held_reg     = '0;
        drop_to_idle();

        halt              = '0;
        halt.stop_bus     = 1'b1;
        rx_enter          = '0;
        rx_enter.enter_receive = 1'b1;
        rx_enter.dummy_read    = 1'b1;

        // Directed table. Typed results only where obvious; the rest go
        // through the model. Rows 1-9 run with the reset slave address 0.
        ev = bus_event(1'b1, 1'b1, 8'hFF);
        dir_rows.push_back('{1'b0, 7'h00, ev, 1'b1, '0});        // event while idle
        dir_rows.push_back('{1'b0, 7'h00, start_req(8'h00, 8'd0), 1'b1, '0}); // count 0
        dir_rows.push_back('{1'b0, 7'h00, start_req(8'hFF, 8'd1), 1'b1,
                             r_tx(1'b1, 1'b0, 8'h00)});
        dir_rows.push_back('{1'b0, 7'h00, bus_event(1'b0, 1'b1, 8'h00), 1'b1, '0});
        dir_rows.push_back('{1'b0, 7'h00, bus_event(1'b1, 1'b1, 8'h00), 1'b1,
                             r_tx(1'b0, 1'b0, 8'hFF)});
        dir_rows.push_back('{1'b0, 7'h00, bus_event(1'b1, 1'b1, 8'h00), 1'b1,
                             r_tx(1'b0, 1'b1, 8'h01)});
        dir_rows.push_back('{1'b0, 7'h00, bus_event(1'b1, 1'b1, 8'h00), 1'b1, rx_enter});
        // single-byte read: last byte at once, no NACK request
        dir_rows.push_back('{1'b0, 7'h00, bus_event(1'b1, 1'b1, 8'hA5), 1'b1,
                             r_store(8'd0, 8'hA5, 1'b0, 1'b1)});
        dir_rows.push_back('{1'b0, 7'h00, bus_event(1'b1, 1'b1, 8'h5A), 1'b1, '0});
        // top slave address, max count, then NACK on the address byte
        dir_rows.push_back('{1'b1, 7'h7F, start_req(8'h5A, 8'd255), 1'b1,
                             r_tx(1'b1, 1'b0, 8'hFE)});
        dir_rows.push_back('{1'b0, 7'h00, bus_event(1'b1, 1'b0, 8'h00), 1'b1, halt});
        // two-byte read: NACK flagged with the first byte
        dir_rows.push_back('{1'b0, 7'h00, start_req(8'h5A, 8'd2), 1'b1,
                             r_tx(1'b1, 1'b0, 8'hFE)});
        dir_rows.push_back('{1'b0, 7'h00, bus_event(1'b1, 1'b1, 8'h11), 1'b0, '0});
        dir_rows.push_back('{1'b0, 7'h00, bus_event(1'b1, 1'b1, 8'h22), 1'b0, '0});
        dir_rows.push_back('{1'b0, 7'h00, bus_event(1'b1, 1'b1, 8'h33), 1'b0, '0});
        dir_rows.push_back('{1'b0, 7'h00, bus_event(1'b1, 1'b0, 8'h00), 1'b1,
                             r_store(8'd0, 8'h00, 1'b1, 1'b0)});
        dir_rows.push_back('{1'b0, 7'h00, bus_event(1'b1, 1'b1, 8'hFF), 1'b1,
                             r_store(8'd1, 8'hFF, 1'b0, 1'b1)});
        // restart while a read is in flight
        dir_rows.push_back('{1'b0, 7'h00, start_req(8'h00, 8'd3), 1'b0, '0});
        dir_rows.push_back('{1'b0, 7'h00, bus_event(1'b1, 1'b1, 8'h00), 1'b0, '0});
        dir_rows.push_back('{1'b0, 7'h00, start_req(8'h33, 8'd1), 1'b1,
                             r_tx(1'b1, 1'b0, 8'hFE)});
        dir_rows.push_back('{1'b0, 7'h00, bus_event(1'b1, 1'b1, 8'h00), 1'b0, '0});
        dir_rows.push_back('{1'b0, 7'h00, bus_event(1'b1, 1'b1, 8'h00), 1'b0, '0});
        dir_rows.push_back('{1'b0, 7'h00, bus_event(1'b1, 1'b1, 8'h00), 1'b0, '0});
        // not-busy event in receive mode is ignored
        dir_rows.push_back('{1'b0, 7'h00, bus_event(1'b0, 1'b0, 8'h77), 1'b1, '0});
        dir_rows.push_back('{1'b0, 7'h00, bus_event(1'b1, 1'b1, 8'h3C), 1'b1,
                             r_store(8'd0, 8'h3C, 1'b0, 1'b1)});

        // single reset pulse
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].set_addr)
                write_slave_address(dir_rows[i].addr_val);
            send_req(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end

        // random part: sender sparse, receiver stalling hard
        write_slave_address(7'h2A);
        random_phase(270);

        // roles swapped
        write_slave_address(7'h55);
        src_idle_pct = 64;
        snk_idle_pct = 32;
        random_phase(270);

        // full throughput, including one full-length 255-byte read
        write_slave_address(7'($urandom_range(127)));
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_read(8'd255, 258, 1'b0);
        random_phase(90);

        // drain, then allow the two-stage pipeline to settle
        hold_until_drained();
        repeat (6) @(posedge clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end

        $display("Run: %0d requests (%0d starts, %0d bus events), %0d address writes.",
                 req_total, start_total, event_total, cfg_writes);
        $display("Seen: %0d finished reads, %0d NACK/early stops, %0d bytes stored.",
                 reads_done, nack_stops, bytes_stored);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
